// ===== rtl/utf8_code_point_segmenter_macros.svh =====
// Assertion macros shared by the segmenter modules.
// Both expect the clock clk and the reset arst_n in scope.
`ifndef UTF8_CODE_POINT_SEGMENTER_MACROS_SVH
`define UTF8_CODE_POINT_SEGMENTER_MACROS_SVH
`ifndef SYNTHESIS
`define SEG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("utf8 segmenter check failed");
`define SEG_ASSERT_NEXT(label, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("utf8 segmenter sequence check failed");
`else
`define SEG_ASSERT(label, prop)
`define SEG_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

// ===== rtl/utf8seg_pkg.sv =====
package utf8seg_pkg;

	localparam int TDATA_W = 40;

	typedef struct packed {
		logic [7:0] code_unit;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic [7:0] byte_third;
		logic [7:0] byte_fourth;
		logic [2:0] byte_count;
		logic       replaced;
		logic       last_of_run;
	} res_t;

	// Up to two results produced by one byte, first in r0.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} step_out_t;

	localparam res_t REPL_RES = '{
		byte_first:  8'hEF,
		byte_second: 8'hBF,
		byte_third:  8'hBD,
		byte_fourth: 8'h00,
		byte_count:  3'd3,
		replaced:    1'b1,
		last_of_run: 1'b0
	};

	function automatic logic is_cont_byte(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// Trail bytes a lead expects; zero for anything that is not a valid lead.
	function automatic logic [1:0] lead_need(input logic [7:0] b);
		logic [1:0] need;
		need = 2'd0;
		if (b >= 8'hC2 && b <= 8'hDF) begin
			need = 2'd1;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			need = 2'd2;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			need = 2'd3;
		end
		return need;
	endfunction

endpackage

// ===== rtl/utf8seg_inreg.sv =====
module utf8seg_inreg
	import utf8seg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] code_unit
	input  logic       s_axis_tlast,   // end_of_string
	input  logic       take,
	output logic       item_valid,
	output in_item_t   item
);

	logic     valid_s1;
	in_item_t item_s1;

	assign s_axis_tready = !valid_s1 || take;
	assign item_valid    = valid_s1;
	assign item          = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{code_unit: s_axis_tdata, end_of_string: s_axis_tlast};
		end
	end

endmodule

// ===== rtl/utf8seg_step.sv =====
`include "utf8_code_point_segmenter_macros.svh"

module utf8seg_step
	import utf8seg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	output step_out_t step_out
);

	logic [23:0] pbytes_q;
	logic [1:0]  pcount_q;
	logic [1:0]  need_q;
	logic        absorb_q;

	logic [23:0] pbytes_d;
	logic [1:0]  pcount_d;
	logic [1:0]  need_d;
	logic        absorb_d;

	logic [7:0]  b;
	logic        eos;
	logic        trail;

	// byte taken as if nothing were open
	logic        fr_en;
	res_t        fr_res;
	logic [1:0]  fr_need;
	logic        fr_open;
	logic        fr_absorb;

	logic        lead_repl;
	logic        use_fresh;
	logic        tail_en;
	res_t        tail_res;
	logic [23:0] merged;
	logic [1:0]  need_dec;

	assign b     = item.code_unit;
	assign eos   = item.end_of_string;
	assign trail = is_cont_byte(b);

	always_comb begin
		fr_need   = lead_need(b);
		fr_en     = 1'b0;
		fr_res    = '0;
		fr_open   = 1'b0;
		fr_absorb = 1'b0;
		if (!b[7]) begin
			fr_en             = 1'b1;
			fr_res.byte_first = b;
			fr_res.byte_count = 3'd1;
		end else if (trail || eos) begin
			fr_en  = 1'b1;
			fr_res = REPL_RES;
		end else if (fr_need == 2'd0) begin
			fr_absorb = 1'b1;
		end else begin
			fr_open = 1'b1;
		end
	end

	always_comb begin
		case (pcount_q)
			2'd1:    merged = pbytes_q | {8'h00, b, 8'h00};
			2'd2:    merged = pbytes_q | {b, 16'h0000};
			default: merged = pbytes_q;
		endcase
	end

	assign need_dec = need_q - 2'd1;

	always_comb begin
		pbytes_d  = pbytes_q;
		pcount_d  = pcount_q;
		need_d    = need_q;
		absorb_d  = absorb_q;
		lead_repl = 1'b0;
		use_fresh = 1'b0;
		tail_en   = 1'b0;
		tail_res  = '0;
		if (absorb_q) begin
			if (!trail) begin
				lead_repl = 1'b1;
				use_fresh = 1'b1;
			end else if (eos) begin
				absorb_d = 1'b0;
				tail_en  = 1'b1;
				tail_res = REPL_RES;
			end
		end else if (pcount_q != 2'd0) begin
			if (!trail) begin
				lead_repl = 1'b1;
				use_fresh = 1'b1;
			end else if (need_dec == 2'd0 || pcount_q == 2'd3) begin
				// sequence complete
				tail_en              = 1'b1;
				tail_res.byte_first  = merged[7:0];
				tail_res.byte_second = merged[15:8];
				tail_res.byte_third  = merged[23:16];
				tail_res.byte_fourth = (pcount_q == 2'd3) ? b : 8'h00;
				tail_res.byte_count  = {1'b0, pcount_q} + 3'd1;
				pbytes_d             = '0;
				pcount_d             = 2'd0;
				need_d               = 2'd0;
			end else if (eos) begin
				tail_en  = 1'b1;
				tail_res = REPL_RES;
				pbytes_d = '0;
				pcount_d = 2'd0;
				need_d   = 2'd0;
			end else begin
				pbytes_d = merged;
				pcount_d = pcount_q + 2'd1;
				need_d   = need_dec;
			end
		end else begin
			use_fresh = 1'b1;
		end

		if (use_fresh) begin
			tail_en  = fr_en;
			tail_res = fr_res;
			pbytes_d = fr_open ? {16'h0000, b} : 24'h000000;
			pcount_d = fr_open ? 2'd1 : 2'd0;
			need_d   = fr_open ? fr_need : 2'd0;
			absorb_d = fr_absorb;
		end
	end

	// Order the results: an interrupted segment always comes first.
	always_comb begin
		step_out = '0;
		if (lead_repl) begin
			step_out.r0 = REPL_RES;
			if (tail_en) begin
				step_out.n              = 2'd2;
				step_out.r1             = tail_res;
				step_out.r1.last_of_run = 1'b1;
			end else begin
				step_out.n              = 2'd1;
				step_out.r0.last_of_run = 1'b1;
			end
		end else if (tail_en) begin
			step_out.n              = 2'd1;
			step_out.r0             = tail_res;
			step_out.r0.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbytes_q <= '0;
			pcount_q <= 2'd0;
			need_q   <= 2'd0;
			absorb_q <= 1'b0;
		end else if (fire) begin
			pbytes_q <= pbytes_d;
			pcount_q <= pcount_d;
			need_q   <= need_d;
			absorb_q <= absorb_d;
		end
	end

	`SEG_ASSERT(a_absorb_excl, !(absorb_q && (pcount_q != 2'd0)))
	`SEG_ASSERT(a_open_needs_trail, (pcount_q == 2'd0) || (need_q != 2'd0))
	`SEG_ASSERT_NEXT(a_absorb_hold, absorb_q && !fire, absorb_q)

endmodule

// ===== rtl/utf8seg_outbuf.sv =====
`include "utf8_code_point_segmenter_macros.svh"

module utf8seg_outbuf
	import utf8seg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  step_out_t          step_out,
	output logic               free,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tuser,
	output logic               m_axis_tlast
);

	logic [1:0] cnt_q;
	res_t       res0_q;
	res_t       res1_q;

	assign m_axis_tvalid = cnt_q != 2'd0;
	// the last word left may be replaced in the cycle it is taken
	assign free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

	assign m_axis_tdata = {5'b00000, res0_q.byte_count, res0_q.byte_fourth,
		res0_q.byte_third, res0_q.byte_second, res0_q.byte_first};
	assign m_axis_tuser = res0_q.replaced;
	assign m_axis_tlast = res0_q.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step_out.n;
		end else if (m_axis_tvalid && m_axis_tready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= step_out.r0;
			res1_q <= step_out.r1;
		end else if (m_axis_tvalid && m_axis_tready && cnt_q == 2'd2) begin
			// advance the second word
			res0_q <= res1_q;
		end
	end

	`SEG_ASSERT(a_cnt_range, cnt_q != 2'd3)
	`SEG_ASSERT(a_pair_lead, (cnt_q != 2'd2) || (res0_q.replaced && !res0_q.last_of_run))

endmodule

// ===== rtl/utf8_code_point_segmenter.sv =====
// UTF-8 code point segmenter: takes one byte per word (tlast marks the end of
// the string) and emits one word per code point with its 1 to 4 bytes and the
// byte count; malformed input (stray trail, missing trails, an invalid lead
// with the trails it swallows, or a sequence cut off by end of string) comes
// out as EF BF BD with tuser set. tlast on the output marks the last word a
// given input byte produced. A byte is taken every cycle while the output
// keeps up; a byte that breaks an open sequence can yield two words, which
// fill the two-slot output register, so the next byte is held back while
// both are in it. An accepted byte goes to the input register, and the
// combinational decode of it then loads the output register.
module utf8_code_point_segmenter
	import utf8seg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] code_unit
	input  logic               s_axis_tlast,   // end_of_string
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [7:0] byte_first, [15:8] byte_second, [23:16] byte_third,
	// [31:24] byte_fourth, [34:32] byte_count, [39:35] zero
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tuser,   // replaced
	output logic               m_axis_tlast    // last_of_run
);

	logic      item_valid;
	in_item_t  item;
	logic      free;
	logic      fire;
	step_out_t step_out;

	assign fire = item_valid && free;

	utf8seg_inreg u_inreg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.take          (free),
		.item_valid    (item_valid),
		.item          (item)
	);

	utf8seg_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item),
		.step_out (step_out)
	);

	utf8seg_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.step_out      (step_out),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== sim/utf8_code_point_segmenter_checker.sv =====
module utf8_code_point_segmenter_checker
	import utf8seg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,
	input  logic               s_axis_tlast,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,
	input  logic               m_axis_tuser,
	input  logic               m_axis_tlast,
	output int                 mismatch_count,
	output int                 words_outstanding
);

	localparam res_t REPLACEMENT_CHAR = '{
		byte_first:  8'hEF,
		byte_second: 8'hBF,
		byte_third:  8'hBD,
		byte_fourth: 8'h00,
		byte_count:  3'd3,
		replaced:    1'b1,
		last_of_run: 1'b0
	};

	// Open sequence as seen by the predictor
	logic [23:0] open_bytes;
	logic [1:0]  open_len;
	logic [1:0]  trails_left;
	logic        swallowing;

	res_t step_points[$];
	res_t expected_points[$];

	function automatic res_t code_point(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] len);
		res_t r;
		r.byte_first  = b0;
		r.byte_second = b1;
		r.byte_third  = b2;
		r.byte_fourth = b3;
		r.byte_count  = len;
		r.replaced    = 1'b0;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	task automatic close_sequence();
		open_bytes  = '0;
		open_len    = '0;
		trails_left = '0;
		swallowing  = 1'b0;
	endtask

	// append one predicted word for the current byte
	task automatic add_point(input res_t p);
		step_points.insert(step_points.size(), p);
	endtask

	// Byte arriving with nothing open
	task automatic take_fresh(input logic [7:0] cu, input logic eos);
		logic [1:0] want;
		want = 2'd0;
		if (cu[7] == 1'b0) begin
			add_point(code_point(cu, 8'h00, 8'h00, 8'h00, 3'd1));
		end else if (cu[7:6] == 2'b10) begin
			add_point(REPLACEMENT_CHAR);
		end else begin
			if (cu >= 8'hC2 && cu <= 8'hDF) begin
				want = 2'd1;
			end else if (cu >= 8'hE0 && cu <= 8'hEF) begin
				want = 2'd2;
			end else if (cu >= 8'hF0 && cu <= 8'hF4) begin
				want = 2'd3;
			end
			if (eos) begin
				close_sequence();
				add_point(REPLACEMENT_CHAR);
			end else if (want == 2'd0) begin
				swallowing = 1'b1;
			end else begin
				open_bytes  = {16'h0000, cu};
				open_len    = 2'd1;
				trails_left = want;
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] cu, input logic eos);
		logic is_cont;
		is_cont = (cu[7:6] == 2'b10);
		step_points.delete();
		if (swallowing) begin
			if (!is_cont) begin
				close_sequence();
				add_point(REPLACEMENT_CHAR);
				take_fresh(cu, eos);
			end else if (eos) begin
				close_sequence();
				add_point(REPLACEMENT_CHAR);
			end
		end else if (open_len != 2'd0) begin
			if (!is_cont) begin
				close_sequence();
				add_point(REPLACEMENT_CHAR);
				take_fresh(cu, eos);
			end else if (open_len == 2'd3) begin
				// fourth byte always completes the sequence
				add_point(code_point(open_bytes[7:0], open_bytes[15:8],
					open_bytes[23:16], cu, 3'd4));
				close_sequence();
			end else begin
				open_bytes[open_len*8 +: 8] = cu;
				open_len    = open_len + 2'd1;
				trails_left = trails_left - 2'd1;
				if (trails_left == 2'd0) begin
					add_point(code_point(open_bytes[7:0], open_bytes[15:8],
						open_bytes[23:16], 8'h00, {1'b0, open_len}));
					close_sequence();
				end else if (eos) begin
					close_sequence();
					add_point(REPLACEMENT_CHAR);
				end
			end
		end else begin
			take_fresh(cu, eos);
		end
		if (step_points.size() > 0) begin
			step_points[step_points.size()-1].last_of_run = 1'b1;
		end
		foreach (step_points[i]) begin
			expected_points.insert(expected_points.size(), step_points[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			close_sequence();
			expected_points.delete();
			mismatch_count = 0;
			words_outstanding <= 0;
		end else begin
			// compare before predicting: no word can leave in the cycle its byte enters
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected word: tdata %0h tuser %0b tlast %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					mismatch_count++;
				end else begin
					want = expected_points.pop_front();
					check_field("byte_first", want.byte_first, m_axis_tdata[7:0]);
					check_field("byte_second", want.byte_second, m_axis_tdata[15:8]);
					check_field("byte_third", want.byte_third, m_axis_tdata[23:16]);
					check_field("byte_fourth", want.byte_fourth, m_axis_tdata[31:24]);
					check_field("byte_count", {5'b0, want.byte_count},
						{5'b0, m_axis_tdata[34:32]});
					check_field("tdata_pad", 8'h00, {3'b0, m_axis_tdata[TDATA_W-1:35]});
					check_field("replaced", {7'b0, want.replaced}, {7'b0, m_axis_tuser});
					check_field("last_of_run", {7'b0, want.last_of_run},
						{7'b0, m_axis_tlast});
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
			end
			words_outstanding <= expected_points.size();
		end
	end

endmodule

// ===== sim/utf8_code_point_segmenter_test.sv =====
module utf8_code_point_segmenter_test;
	import utf8seg_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int DIRECTED_ITEMS = 26;

	// {end_of_string, code_unit}
	localparam logic [8:0] DIRECTED_BYTES [DIRECTED_ITEMS] = '{
		9'h000, 9'h17F,                 // ASCII extremes, string end on plain byte
		9'h080,                         // stray trail
		9'h0C2, 9'h0BF,                 // two-byte
		9'h0EF, 9'h0BF, 9'h0BF,         // three-byte
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // four-byte, highest lead
		9'h0C0, 9'h080,                 // invalid lead swallowing a trail
		9'h0FF, 9'h1BF,                 // invalid lead interrupts, string ends on trail
		9'h0E2, 9'h082, 9'h041,         // ASCII cuts a sequence short
		9'h1F0,                         // lead alone at string end
		9'h0E0, 9'h1A0,                 // string ends mid-sequence
		9'h0DF, 9'h1C1,                 // invalid lead interrupts, then ends the string
		9'h0F5, 9'h100                  // swallowing closed by ASCII at string end
	};

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;

	int       mismatch_count;
	int       results_pending;
	int       burst_left = 0;
	int       bytes_sent = 0;
	int       rx_phase = 0;
	rx_mode_t rx_mode = RX_OPEN;

	utf8_code_point_segmenter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	utf8_code_point_segmenter_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.s_axis_tlast      (s_axis_tlast),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.m_axis_tuser      (m_axis_tuser),
		.m_axis_tlast      (m_axis_tlast),
		.mismatch_count    (mismatch_count),
		.words_outstanding (results_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: switch stall behavior whenever the phase counter runs out
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_phase <= $urandom_range(50, 300);
		end else begin
			rx_phase <= rx_phase - 1;
		end
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: m_axis_tready <= (rx_phase % 4 == 0);
			default: m_axis_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_byte(input logic [7:0] cu, input logic eos);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cu;
		s_axis_tlast  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		bytes_sent++;
	endtask

	// hold off the sender until every predicted word has left the block
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	function automatic logic [7:0] random_trail();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	// lead byte for a given number of trails; zero picks an invalid lead
	function automatic logic [7:0] pick_lead(input int trails);
		int r;
		case (trails)
			1: return 8'($urandom_range(8'hC2, 8'hDF));
			2: return 8'($urandom_range(8'hE0, 8'hEF));
			3: return 8'($urandom_range(8'hF0, 8'hF4));
			default: begin
				r = $urandom_range(0, 12);
				return (r < 2) ? 8'(32'hC0 + r) : 8'(32'hF3 + r);
			end
		endcase
	endfunction

	task automatic send_run(input logic [7:0] lead, input int trails, input logic eos);
		send_byte(lead, eos && trails == 0);
		for (int i = 0; i < trails; i++) begin
			send_byte(random_trail(), eos && i == trails - 1);
		end
	endtask

	task automatic send_sequence();
		int kind;
		int need;
		logic eos;
		kind = $urandom_range(0, 99);
		eos = ($urandom_range(0, 7) == 0);
		if (kind < 25) begin
			send_byte(8'($urandom_range(0, 127)), eos);
		end else if (kind < 72) begin
			// well-formed multi-byte, weighted toward shorter ones
			need = (kind < 45) ? 1 : (kind < 60) ? 2 : 3;
			send_run(pick_lead(need), need, eos);
		end else if (kind < 80) begin
			need = $urandom_range(1, 3);
			send_run(pick_lead(need), $urandom_range(0, need - 1), eos);
		end else if (kind < 86) begin
			send_run(pick_lead(0), $urandom_range(0, 3), eos);
		end else if (kind < 92) begin
			send_byte(random_trail(), eos);
		end else begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int runs;
		runs = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_BYTES[i]) begin
			send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
		end
		wait_for_drain();
		while (bytes_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			send_sequence();
			runs++;
			if (runs == 200) begin
				wait_for_drain();
			end
		end
		wait_for_drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
